// ----- rtl/adcmv_pkg.sv -----
// Shared types and constants for the ADC code to millivolts scaler.
// Used by adcmv_div and adc_code_to_millivolts_unit; depends on nothing.
package adcmv_pkg;

  // Field and register widths
  localparam int CODE_W  = 12;
  localparam int LOW_W   = 12;
  localparam int SPAN_W  = 13;
  localparam int MIN_W   = 16;
  localparam int SSPAN_W = 17;
  localparam int CFG_W   = 17;
  localparam int IDX_W   = 2;
  localparam int OUT_W   = 16;

  // Pin scaling: code * 3300 / full scale, full scale in 255..65535
  localparam int PIN_MV_FULL        = 3300;
  localparam int ADC_FULL_SCALE_DEF = 4095;
  localparam int FS_W               = 16;
  localparam int N2_W               = 24;
  localparam int PIN_W              = 16;
  localparam int RECIP_SHIFT        = 39;
  localparam int RECIP_W            = 32;

  // Span scaling
  localparam int DIFF_W        = 17;
  localparam int PROD_W        = 34;
  localparam int QUO_W         = 32;
  localparam int DIV_W         = 12;
  localparam int DIV_STEPS_DEF = 4;
  localparam int SUM_W         = 34;

  // Register reset values
  localparam logic [LOW_W-1:0]          ADC_LOW_RST    = 12'd0;
  localparam logic signed [SPAN_W-1:0]  ADC_SPAN_RST   = 13'sd3300;
  localparam logic signed [MIN_W-1:0]   SIG_MIN_RST    = -16'sd5000;
  localparam logic signed [SSPAN_W-1:0] SIG_SPAN_RST   = 17'sd10000;

  localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(32768);

  typedef enum logic [IDX_W-1:0] {
    REG_ADC_LOW  = 2'd0,
    REG_ADC_SPAN = 2'd1,
    REG_SIG_MIN  = 2'd2,
    REG_SIG_SPAN = 2'd3
  } cfg_reg_t;

  // Word carried through the divider: magnitude in, quotient out
  typedef struct packed {
    logic             neg;
    logic [QUO_W-1:0] mag;
  } div_word_t;

endpackage

// ----- rtl/adcmv_div.sv -----
// Pipelined restoring divider: unsigned magnitude by a 12-bit divisor,
// a fixed number of quotient bits per stage. Depends on adcmv_pkg.
module adcmv_div
  import adcmv_pkg::*;
#(
  parameter int DIV_STEPS = DIV_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [DIV_W-1:0] divisor,
  input  logic             up_valid,
  output logic             up_ready,
  input  div_word_t        up_word,
  output logic             dn_valid,
  input  logic             dn_ready,
  output div_word_t        dn_word
);

  localparam int STAGES = QUO_W / DIV_STEPS;

  logic [STAGES-1:0] v_q;
  logic [STAGES-1:0] adv;
  div_word_t         word_q [STAGES];
  logic [DIV_W-1:0]  rem_q  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    div_word_t        src_word;
    logic [DIV_W-1:0] src_rem;
    logic             src_v;
    logic             next_ready;
    div_word_t        word_c;
    logic [DIV_W-1:0] rem_c;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;

    if (s == 0) begin : g_first
      assign src_word = up_word;
      assign src_rem  = '0;
      assign src_v    = up_valid;
    end else begin : g_rest
      assign src_word = word_q[s-1];
      assign src_rem  = rem_q[s-1];
      assign src_v    = v_q[s-1];
    end

    if (s == STAGES - 1) begin : g_last
      assign next_ready = dn_ready;
    end else begin : g_mid
      assign next_ready = adv[s+1];
    end

    assign adv[s] = !v_q[s] || next_ready;

    // Shift one dividend bit into the remainder per step; quotient bits
    // fill the dividend from the bottom.
    always_comb begin
      word_c = src_word;
      rem_c  = src_rem;
      trial  = '0;
      diff   = '0;
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial      = {rem_c, word_c.mag[QUO_W-1]};
        word_c.mag = {word_c.mag[QUO_W-2:0], 1'b0};
        diff       = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor}) begin
          rem_c         = diff[DIV_W-1:0];
          word_c.mag[0] = 1'b1;
        end else begin
          rem_c = trial[DIV_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (adv[s]) begin
        v_q[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        word_q[s] <= word_c;
        rem_q[s]  <= rem_c;
      end
    end
  end

  assign up_ready = adv[0];
  assign dn_valid = v_q[STAGES-1];
  assign dn_word  = word_q[STAGES-1];

  // The remainder of the first stage always stays below the divisor
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    v_q[0] |-> (rem_q[0] < divisor))
    else $error("divider remainder reached the divisor");

  // A held last stage keeps its quotient
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (dn_valid && !dn_ready) |=> (dn_valid && $stable(dn_word)))
    else $error("divider output changed while held");

  // Divisor is never zero while work is in flight
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (|v_q) |-> (divisor != '0))
    else $error("divider saw a zero divisor");

endmodule

// ----- rtl/adc_code_to_millivolts_unit.sv -----
// Top level of the ADC code to millivolts scaler: configuration registers,
// front pipeline, divider instance and saturating output. Uses adcmv_pkg.
//
// Converts one raw ADC code per word into a calibrated signal voltage in
// millivolts. The code is scaled to pin millivolts (code * 3300 / full
// scale, rounded half away from zero), the calibrated low point is
// removed, the difference is scaled by signal span over ADC span (same
// rounding), the signal minimum is added and the sum saturates to 16 bits.
// A nonpositive ADC span is used as one. The block takes one word per
// cycle while the result channel is not stalled. The pipeline holds five
// front stages (pin numerator, reciprocal estimate, estimate correction,
// span multiply, magnitude and rounding offset), the divider stages at
// DIV_STEPS quotient bits each, and the output register. Each stage
// advances when it is empty or its successor advances, so bubbles are
// squeezed out and a word is taken whilst a finished result waits.
// Write registers only while idle.
module adc_code_to_millivolts_unit
  import adcmv_pkg::*;
#(
  parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEF,
  parameter int DIV_STEPS      = DIV_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_index,
  input  logic [CFG_W-1:0]         wr_data,
  // sample channel
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic [CODE_W-1:0]        adc_code,
  // result channel
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [OUT_W-1:0]  signal_mv
);

  // Full scale below one is used as one
  localparam int FS_EFF = (ADC_FULL_SCALE < 1) ? 1 : ADC_FULL_SCALE;
  localparam logic [FS_W-1:0]    FS_C    = FS_W'(FS_EFF);
  localparam logic [N2_W-1:0]    FS_HALF = N2_W'(FS_EFF / 2);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'((64'd1 << RECIP_SHIFT) / FS_EFF);
  localparam logic [PIN_W-1:0]   PIN_MAX =
    PIN_W'(((1 << CODE_W) - 1) * PIN_MV_FULL / FS_EFF + 1);

  // Configuration registers
  logic [LOW_W-1:0]          cal_low_mv;
  logic signed [SPAN_W-1:0]  adc_span_mv;
  logic signed [MIN_W-1:0]   cal_floor_mv;
  logic signed [SSPAN_W-1:0] signal_span_mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_low_mv     <= ADC_LOW_RST;
      adc_span_mv    <= ADC_SPAN_RST;
      cal_floor_mv   <= SIG_MIN_RST;
      signal_span_mv <= SIG_SPAN_RST;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_ADC_LOW:  cal_low_mv     <= wr_data[LOW_W-1:0];
        REG_ADC_SPAN: adc_span_mv    <= wr_data[SPAN_W-1:0];
        REG_SIG_MIN:  cal_floor_mv   <= wr_data[MIN_W-1:0];
        REG_SIG_SPAN: signal_span_mv <= wr_data;
      endcase
    end
  end

  // Divisor, rounding half: user keeps static with words in flight; unchecked
  logic [DIV_W-1:0] divisor;
  logic [DIV_W-1:0] div_half;

  assign divisor  = (adc_span_mv <= 0) ? DIV_W'(1) : adc_span_mv[DIV_W-1:0];
  assign div_half = divisor >> 1;

  // Stage valids and advance chain
  logic a_v, b_v, c_v, d_v, e_v;
  logic a_adv, b_adv, c_adv, d_adv, e_adv, out_adv;
  logic div_ready;
  logic div_valid;
  div_word_t div_out;

  assign out_adv      = !result_valid || !result_stall;
  assign e_adv        = !e_v || div_ready;
  assign d_adv        = !d_v || e_adv;
  assign c_adv        = !c_v || d_adv;
  assign b_adv        = !b_v || c_adv;
  assign a_adv        = !a_v || b_adv;
  assign sample_stall = !a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v          <= 1'b0;
      b_v          <= 1'b0;
      c_v          <= 1'b0;
      d_v          <= 1'b0;
      e_v          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (a_adv) a_v <= sample_valid;
      if (b_adv) b_v <= a_v;
      if (c_adv) c_v <= b_v;
      if (d_adv) d_v <= c_v;
      if (e_adv) e_v <= d_v;
      if (out_adv) result_valid <= div_valid;
    end
  end

  // Stage A: rounded numerator of the pin scaling
  logic [N2_W-1:0] a_n2;

  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_n2 <= N2_W'(adc_code) * N2_W'(PIN_MV_FULL) + FS_HALF;
    end
  end

  // Stage B: quotient estimate by reciprocal; low by at most one
  logic [N2_W+RECIP_W-1:0] b_mult;
  logic [N2_W-1:0]         b_n2;
  logic [PIN_W-1:0]        b_q0;

  assign b_mult = (N2_W+RECIP_W)'(a_n2) * (N2_W+RECIP_W)'(RECIP_C);

  always_ff @(posedge clk) begin
    if (b_adv) begin
      b_n2 <= a_n2;
      b_q0 <= b_mult[RECIP_SHIFT +: PIN_W];
    end
  end

  // Stage C: correct the estimate against the true remainder
  logic [2*PIN_W-1:0] c_back;
  logic [N2_W-1:0]    c_rem;
  logic [PIN_W-1:0]   c_pin;

  assign c_back = (2*PIN_W)'(b_q0) * (2*PIN_W)'(FS_C);
  assign c_rem  = b_n2 - c_back[N2_W-1:0];

  always_ff @(posedge clk) begin
    if (c_adv) begin
      c_pin <= (c_rem >= N2_W'(FS_C)) ? b_q0 + PIN_W'(1) : b_q0;
    end
  end

  // Stage D: remove the low point and scale by the signal span
  logic signed [DIFF_W-1:0] d_diff;
  logic signed [PROD_W-1:0] d_prod;

  assign d_diff = $signed({1'b0, c_pin}) - $signed({(DIFF_W-LOW_W)'(0), cal_low_mv});

  always_ff @(posedge clk) begin
    if (d_adv) begin
      d_prod <= PROD_W'(d_diff) * PROD_W'(signal_span_mv);
    end
  end

  // Stage E: take the magnitude and add the rounding half
  logic signed [PROD_W-1:0] e_abs;
  div_word_t                e_word;

  assign e_abs = d_prod[PROD_W-1] ? -d_prod : d_prod;

  always_ff @(posedge clk) begin
    if (e_adv) begin
      e_word.neg <= d_prod[PROD_W-1];
      e_word.mag <= e_abs[QUO_W-1:0] + QUO_W'(div_half);
    end
  end

  adcmv_div #(
    .DIV_STEPS (DIV_STEPS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .divisor  (divisor),
    .up_valid (e_v),
    .up_ready (div_ready),
    .up_word  (e_word),
    .dn_valid (div_valid),
    .dn_ready (out_adv),
    .dn_word  (div_out)
  );

  // Output: restore the sign, add the minimum, saturate
  logic signed [SUM_W-1:0] o_quo;
  logic signed [SUM_W-1:0] o_sum;
  logic signed [OUT_W-1:0] o_sat;

  always_comb begin
    o_quo = $signed({(SUM_W-QUO_W)'(0), div_out.mag});
    if (div_out.neg) begin
      o_quo = -o_quo;
    end
    o_sum = o_quo + SUM_W'(cal_floor_mv);
    if (o_sum > OUT_MAX) begin
      o_sat = OUT_MAX[OUT_W-1:0];
    end else if (o_sum < OUT_MIN) begin
      o_sat = OUT_MIN[OUT_W-1:0];
    end else begin
      o_sat = o_sum[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      signal_mv <= o_sat;
    end
  end

  // Reciprocal estimate is never more than one short
  a_recip_err: assert property (@(posedge clk) disable iff (rst)
    b_v |-> (c_rem < N2_W'(2 * FS_EFF)))
    else $error("pin reciprocal estimate out of range");

  // Corrected pin millivolts stay within the full code range
  a_pin_range: assert property (@(posedge clk) disable iff (rst)
    c_v |-> (c_pin <= PIN_MAX))
    else $error("pin millivolts beyond full scale");

  // An empty output register never holds back a sample
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !sample_stall)
    else $error("sample stalled with an empty output");

  // A stall with a free front stage never happens
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> (a_v && b_v && c_v && d_v && e_v && result_valid))
    else $error("sample stalled with a bubble in the pipeline");

endmodule
